FILE: sv/dhhp_pkg.sv
// Package: shared transaction types and character codes for the hunk header parser.
`default_nettype none

package dhhp_pkg;

    localparam int unsigned OUT_WIDTH = 24;

    localparam logic [7:0] CHAR_AT    = 8'h40;  // '@'
    localparam logic [7:0] CHAR_SPACE = 8'h20;  // ' '
    localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_COMMA = 8'h2C;  // ','
    localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CHAR_TAB   = 8'h09;  // '\t'
    localparam logic [7:0] CHAR_LF    = 8'h0A;  // '\n'
    localparam logic [7:0] CHAR_CR    = 8'h0D;  // '\r'

    typedef struct packed {
        logic [7:0] line_byte;
        logic       line_end;
    } in_item_t;

    typedef struct packed {
        logic                 header_ok;
        logic [OUT_WIDTH-1:0] old_start_line;
        logic [OUT_WIDTH-1:0] old_line_count;
        logic [OUT_WIDTH-1:0] new_line_count;
    } out_item_t;

endpackage : dhhp_pkg

`default_nettype wire

FILE: sv/diff_hunk_header_parser.sv
// Top level: unified-diff hunk header parser with valid/ready byte input and result output.
`default_nettype none

// Hunk header parser. Feed the header line one byte per input transaction,
// with line_end set on its last byte; the block checks the form
// "@@ -a[,b] +c[,d] @@" followed by end of line or a space, tab, LF or CR
// (anything after that byte is ignored), and emits exactly one result
// transaction per line, on the last byte. A malformed line, including a
// number above 2^NUMBER_WIDTH - 1 or a line that ends before the closing
// "@@", gives header_ok = 0 with all number fields zero. Missing counts
// read as 1; the new start is checked but not reported; numbers are
// reported in their low 24 bits. Throughput is one byte per clock while
// in_ready is high: each byte costs one phase update and one multiply-by-ten
// accumulate in the parser, and the result enters the output register as
// the last byte is accepted. The input stays ready while the output register
// is empty or being drained in the same cycle, so a stalled result only
// holds off the input for as long as the consumer withholds out_ready.
module diff_hunk_header_parser
    import dhhp_pkg::*;
#(
    parameter int unsigned NUMBER_WIDTH = 24
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);

    logic      take;
    logic      result_valid;
    out_item_t result;

    logic      out_valid_reg;
    out_item_t out_data_reg;

    // Accept a byte whenever the result slot is free or frees this cycle.
    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    dhhp_parser #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .item         (in_data),
        .result_valid (result_valid),
        .result       (result)
    );

    // Hold the finished result until the consumer takes the transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (result_valid)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (result_valid)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule : diff_hunk_header_parser

`default_nettype wire

FILE: sv/dhhp_parser.sv
// Parser state machine: phase, number accumulator and captured fields, one byte per cycle while take is high.
`default_nettype none

module dhhp_parser
    import dhhp_pkg::*;
#(
    parameter int unsigned NUMBER_WIDTH = 24
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      take,
    input  wire in_item_t  item,
    output logic           result_valid,
    output out_item_t      result
);

    typedef enum logic [3:0] {
        PH_AT1,
        PH_AT2,
        PH_SP1,
        PH_MINUS,
        PH_OSTART,
        PH_OCOUNT,
        PH_PLUS,
        PH_NSTART,
        PH_NCOUNT,
        PH_AT3,
        PH_AT4,
        PH_TAIL,
        PH_DONE
    } phase_t;

    localparam logic [NUMBER_WIDTH-1:0] NUM_ZERO = '0;
    localparam logic [NUMBER_WIDTH-1:0] NUM_ONE  = NUMBER_WIDTH'(1);

    phase_t                  phase_reg,     phase_next;
    logic [NUMBER_WIDTH-1:0] accum_reg,     accum_next;
    logic                    seen_reg,      seen_next;
    logic [NUMBER_WIDTH-1:0] old_start_reg, old_start_next;
    logic [NUMBER_WIDTH-1:0] old_count_reg, old_count_next;
    logic [NUMBER_WIDTH-1:0] new_count_reg, new_count_next;
    logic                    failed_reg,    failed_next;

    logic                    is_digit;
    logic [3:0]              digit_val;
    logic [NUMBER_WIDTH+3:0] times_ten;
    logic                    too_wide;
    logic                    ok;
    logic [NUMBER_WIDTH+OUT_WIDTH-1:0] ext_start, ext_ocount, ext_ncount;

    assign is_digit  = (item.line_byte >= CHAR_ZERO) && (item.line_byte <= CHAR_NINE);
    assign digit_val = item.line_byte[3:0];
    // accum * 10 + digit as (accum << 3) + (accum << 1) + digit
    assign times_ten = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0}
                     + {NUMBER_WIDTH'(0), digit_val};
    assign too_wide  = |times_ten[NUMBER_WIDTH+3:NUMBER_WIDTH];

    always_comb
    begin
        phase_next     = phase_reg;
        accum_next     = accum_reg;
        seen_next      = seen_reg;
        old_start_next = old_start_reg;
        old_count_next = old_count_reg;
        new_count_next = new_count_reg;
        failed_next    = failed_reg;

        if (!failed_reg)
        begin
            unique case (phase_reg)
                PH_AT1, PH_AT2, PH_AT3, PH_AT4:
                begin
                    if (item.line_byte == CHAR_AT)
                        phase_next = phase_t'(phase_reg + 4'd1);
                    else
                        failed_next = 1'b1;
                end
                PH_SP1:
                begin
                    if (item.line_byte == CHAR_SPACE)
                        phase_next = PH_MINUS;
                    else
                        failed_next = 1'b1;
                end
                PH_MINUS, PH_PLUS:
                begin
                    if ((phase_reg == PH_MINUS && item.line_byte == CHAR_MINUS) ||
                        (phase_reg == PH_PLUS && item.line_byte == CHAR_PLUS))
                    begin
                        accum_next = NUM_ZERO;
                        seen_next  = 1'b0;
                        phase_next = (phase_reg == PH_MINUS) ? PH_OSTART : PH_NSTART;
                    end
                    else
                        failed_next = 1'b1;
                end
                PH_OSTART, PH_NSTART, PH_OCOUNT, PH_NCOUNT:
                begin
                    if (is_digit)
                    begin
                        if (too_wide)
                            failed_next = 1'b1;
                        else
                        begin
                            accum_next = times_ten[NUMBER_WIDTH-1:0];
                            seen_next  = 1'b1;
                        end
                    end
                    else if (!seen_reg)
                        failed_next = 1'b1;
                    else if (item.line_byte == CHAR_COMMA &&
                             (phase_reg == PH_OSTART || phase_reg == PH_NSTART))
                    begin
                        if (phase_reg == PH_OSTART)
                            old_start_next = accum_reg;
                        accum_next = NUM_ZERO;
                        seen_next  = 1'b0;
                        phase_next = phase_t'(phase_reg + 4'd1);
                    end
                    else if (item.line_byte == CHAR_SPACE)
                    begin
                        if (phase_reg == PH_OSTART)
                            old_start_next = accum_reg;
                        if (phase_reg == PH_OCOUNT)
                            old_count_next = accum_reg;
                        if (phase_reg == PH_NCOUNT)
                            new_count_next = accum_reg;
                        phase_next = (phase_reg == PH_OSTART || phase_reg == PH_OCOUNT)
                                   ? PH_PLUS : PH_AT3;
                    end
                    else
                        failed_next = 1'b1;
                end
                PH_TAIL:
                begin
                    if (item.line_byte == CHAR_SPACE || item.line_byte == CHAR_TAB ||
                        item.line_byte == CHAR_LF || item.line_byte == CHAR_CR)
                        phase_next = PH_DONE;
                    else
                        failed_next = 1'b1;
                end
                PH_DONE:
                begin
                end
                default:
                    failed_next = 1'b1;
            endcase
        end
    end

    assign ok = !failed_next && (phase_next == PH_TAIL || phase_next == PH_DONE);

    // Zero-extend before taking the low output bits so any NUMBER_WIDTH fits.
    assign ext_start  = {OUT_WIDTH'(0), old_start_next};
    assign ext_ocount = {OUT_WIDTH'(0), old_count_next};
    assign ext_ncount = {OUT_WIDTH'(0), new_count_next};

    assign result_valid          = take && item.line_end;
    assign result.header_ok      = ok;
    assign result.old_start_line = ok ? ext_start[OUT_WIDTH-1:0]  : '0;
    assign result.old_line_count = ok ? ext_ocount[OUT_WIDTH-1:0] : '0;
    assign result.new_line_count = ok ? ext_ncount[OUT_WIDTH-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_AT1;
            accum_reg     <= NUM_ZERO;
            seen_reg      <= 1'b0;
            old_start_reg <= NUM_ZERO;
            old_count_reg <= NUM_ONE;
            new_count_reg <= NUM_ONE;
            failed_reg    <= 1'b0;
        end
        else if (take)
        begin
            if (item.line_end)
            begin
                // Drop all line state so the next byte opens a new line.
                phase_reg     <= PH_AT1;
                accum_reg     <= NUM_ZERO;
                seen_reg      <= 1'b0;
                old_start_reg <= NUM_ZERO;
                old_count_reg <= NUM_ONE;
                new_count_reg <= NUM_ONE;
                failed_reg    <= 1'b0;
            end
            else
            begin
                phase_reg     <= phase_next;
                accum_reg     <= accum_next;
                seen_reg      <= seen_next;
                old_start_reg <= old_start_next;
                old_count_reg <= old_count_next;
                new_count_reg <= new_count_next;
                failed_reg    <= failed_next;
            end
        end
    end

endmodule : dhhp_parser

`default_nettype wire
